/* sv/spb_pkg.sv */
// ----------------------------------------------------------------------------
// spb_pkg: shared definitions for the scaled palette sprite blitter
// Sizes, register indexes and the command and status bundles that pass
// between the blitter controller and its datapath.
// ----------------------------------------------------------------------------
package spb_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int FRAME_WIDTH     = 64;
  localparam int FRAME_HEIGHT    = 64;
  localparam int MAX_SCALE       = 8;

  localparam int PAL_AW  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int COLOR_W = 32;
  localparam int ADDR_W  = 24;
  localparam int DIM_W   = 13;  // framebuffer width and height
  localparam int POS_W   = 16;  // destination corner
  localparam int SCALE_W = 4;
  localparam int SRC_W   = 6;
  localparam int IDX_W   = 8;
  localparam int COORD_W = 18;  // signed block coordinates before clipping
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 16;

  localparam logic [CFG_IW-1:0] CFG_DEST_X        = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_DEST_Y        = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_SCALE_FACTOR  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_BUFFER_WIDTH  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_BUFFER_HEIGHT = 3'd4;

  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_PIXEL   = 1'b1;

  typedef struct packed {
    logic accept;      // an input request is taken this cycle
    logic load_block;  // form the unclipped block corners
    logic load_clip;   // clip the block against the framebuffer
    logic load_base;   // form the first linear address
    logic step;        // the current write request is taken
  } spb_cmd_t;

  typedef struct packed {
    logic draw;   // the offered request is a visible pixel
    logic empty;  // the clipped block holds no cell
    logic last;   // the current write is the final one
  } spb_sts_t;

  // Colour index reduced modulo the palette size by restoring subtraction.
  function automatic logic [PAL_AW-1:0] pal_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+9:0] r;
    r = (IDX_W+10)'(idx);
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if (r >= ((IDX_W+10)'(PALETTE_ENTRIES) << k)) begin
        r = r - ((IDX_W+10)'(PALETTE_ENTRIES) << k);
      end
    end
    return PAL_AW'(r);
  endfunction

endpackage

/* sv/spb_ram.sv */
// ----------------------------------------------------------------------------
// spb_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module spb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/spb_ctrl.sv */
// ----------------------------------------------------------------------------
// spb_ctrl: blitter sequencer
// Steps one pixel request through block forming, clipping, base address
// and the write loop.
// ----------------------------------------------------------------------------
module spb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  spb_pkg::spb_sts_t sts_i,
  output spb_pkg::spb_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BLOCK = 3'd1;
  localparam logic [2:0] S_CLIP  = 3'd2;
  localparam logic [2:0] S_BASE  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o            = '0;
    cmd_o.accept     = accept;
    cmd_o.load_block = (state_q == S_BLOCK);
    cmd_o.load_clip  = (state_q == S_CLIP);
    cmd_o.load_base  = (state_q == S_BASE);
    cmd_o.step       = out_valid_o && out_ready_i;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && sts_i.draw) state_d = S_BLOCK;
      end
      S_BLOCK: state_d = S_CLIP;
      S_CLIP: begin
        state_d = sts_i.empty ? S_IDLE : S_BASE;
      end
      S_BASE: state_d = S_EMIT;
      S_EMIT: begin
        if (out_ready_i && sts_i.last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/spb_dp.sv */
// ----------------------------------------------------------------------------
// spb_dp: blitter datapath
// Configuration registers, palette, block clipping and the address walk.
// ----------------------------------------------------------------------------
module spb_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [spb_pkg::CFG_IW-1:0]          cfg_index_i,
  input  logic [spb_pkg::CFG_DW-1:0]          cfg_data_i,
  input  logic                                kind_i,
  input  logic [spb_pkg::IDX_W-1:0]           entry_number_i,
  input  logic [spb_pkg::COLOR_W-1:0]         entry_color_i,
  input  logic [spb_pkg::IDX_W-1:0]           color_index_i,
  input  logic [spb_pkg::SRC_W-1:0]           src_col_i,
  input  logic [spb_pkg::SRC_W-1:0]           src_row_i,
  input  spb_pkg::spb_cmd_t                   cmd_i,
  output spb_pkg::spb_sts_t                   sts_o,
  output logic [spb_pkg::ADDR_W-1:0]          write_address_o,
  output logic [spb_pkg::COLOR_W-1:0]         write_color_o,
  output logic                                last_write_o
);

  localparam int CW = spb_pkg::COORD_W;
  localparam int BW = spb_pkg::DIM_W;
  localparam int AW = spb_pkg::ADDR_W;
  localparam int SW = spb_pkg::SRC_W;
  localparam int KW = spb_pkg::SCALE_W;

  // Configuration
  logic signed [spb_pkg::POS_W-1:0] dest_x_q, dest_y_q;
  logic [KW-1:0]                    scale_q;
  logic [BW-1:0]                    buf_w_q, buf_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_x_q <= '0;
      dest_y_q <= '0;
      scale_q  <= KW'(1);
      buf_w_q  <= '0;
      buf_h_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        spb_pkg::CFG_DEST_X:        dest_x_q <= cfg_data_i;
        spb_pkg::CFG_DEST_Y:        dest_y_q <= cfg_data_i;
        spb_pkg::CFG_SCALE_FACTOR:  scale_q  <= cfg_data_i[KW-1:0];
        spb_pkg::CFG_BUFFER_WIDTH:  buf_w_q  <= cfg_data_i[BW-1:0];
        spb_pkg::CFG_BUFFER_HEIGHT: buf_h_q  <= cfg_data_i[BW-1:0];
        default: ;
      endcase
    end
  end

  logic [KW-1:0] scale;
  always_comb begin
    priority if (scale_q == '0) begin
      scale = KW'(1);
    end else if (scale_q > KW'(spb_pkg::MAX_SCALE)) begin
      scale = KW'(spb_pkg::MAX_SCALE);
    end else begin
      scale = scale_q;
    end
  end

  // Palette
  logic pal_we;
  assign pal_we = cmd_i.accept && (kind_i == spb_pkg::KIND_PALETTE) &&
                  ({1'b0, entry_number_i} < (spb_pkg::IDX_W+1)'(spb_pkg::PALETTE_ENTRIES));

  spb_ram #(
    .WIDTH (spb_pkg::COLOR_W),
    .DEPTH (spb_pkg::PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (spb_pkg::PAL_AW'(entry_number_i)),
    .wdata_i (entry_color_i),
    .re_i    (cmd_i.accept),
    .raddr_i (spb_pkg::pal_slot(color_index_i)),
    .rdata_o (write_color_o)
  );

  assign sts_o.draw = (kind_i == spb_pkg::KIND_PIXEL) && (color_index_i != '0) &&
                      ({1'b0, src_col_i} < (SW+1)'(spb_pkg::FRAME_WIDTH)) &&
                      ({1'b0, src_row_i} < (SW+1)'(spb_pkg::FRAME_HEIGHT)) &&
                      (buf_w_q != '0) && (buf_h_q != '0);

  // Block corners, then clipped bounds, then the linear address walk.
  logic [SW-1:0]         col_q, row_q;
  logic [SW+KW-1:0]      col_off, row_off;
  logic signed [CW-1:0]  bx, by, bxe, bye;
  logic signed [CW-1:0]  bx_q, by_q, bxe_q, bye_q;
  logic signed [CW-1:0]  w_s, h_s;
  logic [BW-1:0]         x0_d, x1_d, y0_d, y1_d;
  logic [BW-1:0]         x0_q, x1_q, y0_q, y1_q;
  logic [BW-1:0]         x_q, x_d, y_q, y_d;
  logic [2*BW-1:0]       base_prod;
  logic [AW-1:0]         addr_q, addr_d, rowb_q, rowb_d, next_row;
  logic                  empty_x, empty_y;

  assign col_off = col_q * scale;
  assign row_off = row_q * scale;
  assign bx  = CW'(dest_x_q) + signed'(CW'(col_off));
  assign by  = CW'(dest_y_q) + signed'(CW'(row_off));
  assign bxe = bx + signed'(CW'(scale)) - signed'(CW'(1));
  assign bye = by + signed'(CW'(scale)) - signed'(CW'(1));

  assign w_s = signed'(CW'(buf_w_q));
  assign h_s = signed'(CW'(buf_h_q));

  assign empty_x = bxe_q[CW-1] || (bx_q >= w_s);
  assign empty_y = bye_q[CW-1] || (by_q >= h_s);
  assign x0_d = bx_q[CW-1] ? '0 : bx_q[BW-1:0];
  assign y0_d = by_q[CW-1] ? '0 : by_q[BW-1:0];
  assign x1_d = (bxe_q >= w_s) ? buf_w_q - BW'(1) : bxe_q[BW-1:0];
  assign y1_d = (bye_q >= h_s) ? buf_h_q - BW'(1) : bye_q[BW-1:0];
  assign sts_o.empty = empty_x || empty_y;

  assign base_prod = y0_q * buf_w_q;
  assign next_row  = rowb_q + AW'(buf_w_q);

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    addr_d = addr_q;
    rowb_d = rowb_q;
    if (cmd_i.load_base) begin
      x_d    = x0_q;
      y_d    = y0_q;
      rowb_d = AW'(base_prod);
      addr_d = AW'(base_prod) + AW'(x0_q);
    end else if (cmd_i.step) begin
      if (x_q == x1_q) begin
        x_d    = x0_q;
        y_d    = y_q + BW'(1);
        rowb_d = next_row;
        addr_d = next_row + AW'(x0_q);
      end else begin
        x_d    = x_q + BW'(1);
        addr_d = addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      col_q <= src_col_i;
      row_q <= src_row_i;
    end
    if (cmd_i.load_block) begin
      bx_q  <= bx;
      by_q  <= by;
      bxe_q <= bxe;
      bye_q <= bye;
    end
    if (cmd_i.load_clip) begin
      x0_q <= x0_d;
      x1_q <= x1_d;
      y0_q <= y0_d;
      y1_q <= y1_d;
    end
    x_q    <= x_d;
    y_q    <= y_d;
    addr_q <= addr_d;
    rowb_q <= rowb_d;
  end

  assign sts_o.last      = (x_q == x1_q) && (y_q == y1_q);
  assign last_write_o    = sts_o.last;
  assign write_address_o = addr_q;

endmodule

/* sv/scaled_palette_sprite_blitter_top.sv */
// ----------------------------------------------------------------------------
// scaled_palette_sprite_blitter_top: palette sprite blitter with scaling
// Draws palette-indexed sprite pixels as scaled, clipped framebuffer writes.
// ----------------------------------------------------------------------------
// One request is handled at a time. A palette write is done once taken, as
// is a pixel that draws nothing (transparent, outside the sprite frame, or
// an empty framebuffer); a pixel whose block is wholly clipped passes
// through S_BLOCK and S_CLIP back to S_IDLE. A visible pixel looks up its
// colour when taken, forms and clips its block in S_BLOCK and S_CLIP and
// multiplies out the first row address in S_BASE, then gives one write per
// cycle while out_ready_i is high for each cell of the clipped block, scale
// squared at most, row by row, left to right, with last_write_o on the final one.
module scaled_palette_sprite_blitter_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [spb_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [spb_pkg::CFG_DW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic [spb_pkg::IDX_W-1:0]   entry_number_i,
  input  logic [spb_pkg::COLOR_W-1:0] entry_color_i,
  input  logic [spb_pkg::IDX_W-1:0]   color_index_i,
  input  logic [spb_pkg::SRC_W-1:0]   src_col_i,
  input  logic [spb_pkg::SRC_W-1:0]   src_row_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [spb_pkg::ADDR_W-1:0]  write_address_o,
  output logic [spb_pkg::COLOR_W-1:0] write_color_o,
  output logic                        last_write_o
);

  spb_pkg::spb_cmd_t cmd;
  spb_pkg::spb_sts_t sts;

  spb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spb_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .kind_i          (kind_i),
    .entry_number_i  (entry_number_i),
    .entry_color_i   (entry_color_i),
    .color_index_i   (color_index_i),
    .src_col_i       (src_col_i),
    .src_row_i       (src_row_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .write_address_o (write_address_o),
    .write_color_o   (write_color_o),
    .last_write_o    (last_write_o)
  );

  // No new request is taken while writes are still being given out.
  a_no_accept_while_emitting: assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> !in_ready_o
  ) else $error("input taken while writes are pending");

  // A write that is not the last is always followed by another.
  a_block_continues: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_write_o |=> out_valid_o
  ) else $error("write sequence ended without last_write");

  // The last write ends the sequence.
  a_last_ends_block: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_write_o |=> !out_valid_o && in_ready_o
  ) else $error("writes continued after last_write");

endmodule
